### hw/rtl/ppsa_pkg.sv
package ppsa_pkg;

  localparam int unsigned STACK_DEPTH  = 65536;
  localparam int unsigned UNSAFE_SLOTS = 8;
  localparam int unsigned ADDR_BITS    = 52;
  localparam int unsigned PAGE_SHIFT   = 12;

  localparam int unsigned PN_BITS  = ADDR_BITS - PAGE_SHIFT;
  localparam int unsigned PNX_BITS = PN_BITS + 1;
  localparam int unsigned SP_BITS  = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_BITS = SP_BITS + 1;
  localparam int unsigned US_BITS  = (UNSAFE_SLOTS > 1) ? $clog2(UNSAFE_SLOTS) : 1;
  localparam int unsigned UC_BITS  = $clog2(UNSAFE_SLOTS + 1);

  localparam logic [PNX_BITS-1:0] PAGE_LIMIT = {1'b1, {PN_BITS{1'b0}}};

  localparam logic [1:0] MODE_ADD_UNSAFE = 2'd0;
  localparam logic [1:0] MODE_MAP_ENTRY  = 2'd1;
  localparam logic [1:0] MODE_ALLOC      = 2'd2;
  localparam logic [1:0] MODE_FREE       = 2'd3;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_UNUSABLE = 2'd3;

  localparam logic [1:0] KIND_RESERVED  = 2'd0;
  localparam logic [1:0] KIND_DEFECTIVE = 2'd1;
  localparam logic [1:0] KIND_HIBERNATE = 2'd2;

  localparam logic [7:0] TYPE_USABLE    = 8'd1;
  localparam logic [7:0] TYPE_HIBERNATE = 8'd4;
  localparam logic [7:0] TYPE_DEFECTIVE = 8'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_PROBE,
    ST_DECIDE,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic               we;
    logic [SP_BITS-1:0] waddr;
    logic [PN_BITS-1:0] wdata;
    logic               re;
    logic [SP_BITS-1:0] raddr;
  } stack_cmd_t;

  typedef struct packed {
    logic                 load;
    logic [ADDR_BITS-1:0] range_start;
    logic [ADDR_BITS-1:0] range_end;
  } unsafe_cmd_t;

endpackage

### hw/rtl/ppsa_if.sv
interface ppsa_req_if import ppsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           mode;
  logic [ADDR_BITS-1:0] region_base;
  logic [ADDR_BITS-1:0] region_length;
  logic [ADDR_BITS-1:0] region_end;
  logic [7:0]           region_type;
  logic [ADDR_BITS-1:0] freed_page;

  modport source (
    output valid, mode, region_base, region_length, region_end, region_type, freed_page,
    input  ready
  );
  modport sink (
    input  valid, mode, region_base, region_length, region_end, region_type, freed_page,
    output ready
  );
endinterface

interface ppsa_rsp_if import ppsa_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [ADDR_BITS-1:0] page_address;
  logic [CNT_BITS-1:0]  pages_added;
  logic [1:0]           range_kind;
  logic [CNT_BITS-1:0]  free_pages_now;

  modport source (
    output valid, status, page_address, pages_added, range_kind, free_pages_now,
    input  ready
  );
  modport sink (
    input  valid, status, page_address, pages_added, range_kind, free_pages_now,
    output ready
  );
endinterface

### hw/rtl/physical_page_stack_allocator_core.sv
// Free page stack allocator for 4 KiB pages. Each request gives one response.
// Allocate, free, unsafe range loads and unusable map entries are accepted and
// act on the stack memory or the unsafe table in the idle state, then load the
// response register in the result state. A usable map entry passes a setup
// state that clamps the last page, then alternates a probe state, in which the
// page is checked against all unsafe ranges, and a decide state, in which it is
// pushed or skipped, or the entry ends when the stack is full; a hit jumps
// straight past the covering range. A response that is not taken holds the
// block until it is. The stack lives in a single synchronous RAM with one
// write and one read port; no clearing pass is needed after reset.
module physical_page_stack_allocator_core import ppsa_pkg::*; (
  input logic       clk,
  input logic       rst,
  ppsa_req_if.sink  req,
  ppsa_rsp_if.source rsp
);

  state_t              state, state_next;
  logic [PNX_BITS-1:0] pn, pn_next;
  logic [PNX_BITS-1:0] last_pn, last_next;
  logic [CNT_BITS-1:0] count, count_next;
  logic [CNT_BITS-1:0] added, added_next;
  logic [1:0]          res_status, status_next;
  logic [1:0]          res_kind, kind_next;
  logic                res_pop, pop_next;
  logic                load_rsp;

  stack_cmd_t          scmd;
  unsafe_cmd_t         ucmd;
  logic [PN_BITS-1:0]  rdata;
  logic                unsafe_full;
  logic [PNX_BITS-1:0] skip;
  logic                stack_full;
  logic [CNT_BITS-1:0] count_dec;
  logic [PNX_BITS:0]   last_sum;

  assign stack_full = (count == CNT_BITS'(STACK_DEPTH));
  assign count_dec  = count - CNT_BITS'(1);
  assign last_sum   = {1'b0, pn} + {1'b0, last_pn};
  assign req.ready  = (state == ST_IDLE);

  ppsa_stack_mem u_stack (
    .clk   (clk),
    .cmd   (scmd),
    .rdata (rdata)
  );

  ppsa_unsafe_table u_unsafe (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ucmd),
    .probe_pn (pn[PN_BITS-1:0]),
    .full     (unsafe_full),
    .skip     (skip)
  );

  always_comb begin
    state_next       = state;
    pn_next          = pn;
    last_next        = last_pn;
    count_next       = count;
    added_next       = added;
    status_next      = res_status;
    kind_next        = res_kind;
    pop_next         = res_pop;
    load_rsp         = 1'b0;
    scmd             = '0;
    ucmd.load        = 1'b0;
    ucmd.range_start = req.region_base;
    ucmd.range_end   = req.region_end;

    unique case (state)
      ST_IDLE: begin
        if (req.valid) begin
          status_next = STATUS_OK;
          kind_next   = KIND_RESERVED;
          added_next  = '0;
          pop_next    = 1'b0;
          state_next  = ST_RESULT;
          unique case (req.mode)
            MODE_ADD_UNSAFE: begin
              ucmd.load = 1'b1;
              if (unsafe_full) begin
                status_next = STATUS_FULL;
              end
            end
            MODE_MAP_ENTRY: begin
              if (req.region_type == TYPE_USABLE) begin
                pn_next    = {1'b0, req.region_base[ADDR_BITS-1:PAGE_SHIFT]} +
                             PNX_BITS'(|req.region_base[PAGE_SHIFT-1:0]);
                last_next  = {1'b0, req.region_length[ADDR_BITS-1:PAGE_SHIFT]};
                state_next = ST_SETUP;
              end else begin
                status_next = STATUS_UNUSABLE;
                if (req.region_type == TYPE_HIBERNATE) begin
                  kind_next = KIND_HIBERNATE;
                end else if (req.region_type == TYPE_DEFECTIVE) begin
                  kind_next = KIND_DEFECTIVE;
                end
              end
            end
            MODE_ALLOC: begin
              if (count != '0) begin
                count_next = count_dec;
                scmd.re    = 1'b1;
                scmd.raddr = count_dec[SP_BITS-1:0];
                pop_next   = 1'b1;
              end else begin
                status_next = STATUS_EMPTY;
              end
            end
            MODE_FREE: begin
              if (!stack_full) begin
                scmd.we    = 1'b1;
                scmd.waddr = count[SP_BITS-1:0];
                scmd.wdata = req.freed_page[ADDR_BITS-1:PAGE_SHIFT];
                count_next = count + CNT_BITS'(1);
              end else begin
                status_next = STATUS_FULL;
              end
            end
          endcase
        end
      end
      ST_SETUP: begin
        // last page bound, clamped to the address space
        if (last_sum > {1'b0, PAGE_LIMIT}) begin
          last_next = PAGE_LIMIT;
        end else begin
          last_next = last_sum[PNX_BITS-1:0];
        end
        state_next = ST_PROBE;
      end
      ST_PROBE: begin
        if (pn >= last_pn) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (skip != '0) begin
          pn_next    = skip;
          state_next = ST_PROBE;
        end else if (stack_full) begin
          status_next = STATUS_FULL;
          state_next  = ST_RESULT;
        end else begin
          scmd.we    = 1'b1;
          scmd.waddr = count[SP_BITS-1:0];
          scmd.wdata = pn[PN_BITS-1:0];
          count_next = count + CNT_BITS'(1);
          added_next = added + CNT_BITS'(1);
          pn_next    = pn + PNX_BITS'(1);
          state_next = ST_PROBE;
        end
      end
      ST_RESULT: begin
        if (!rsp.valid || rsp.ready) begin
          load_rsp   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    pn         <= pn_next;
    last_pn    <= last_next;
    added      <= added_next;
    res_status <= status_next;
    res_kind   <= kind_next;
    res_pop    <= pop_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (load_rsp) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.status         <= res_status;
      rsp.page_address   <= res_pop ? {rdata, {PAGE_SHIFT{1'b0}}} : '0;
      rsp.pages_added    <= added;
      rsp.range_kind     <= res_kind;
      rsp.free_pages_now <= count;
    end
  end

endmodule

### hw/rtl/ppsa_stack_mem.sv
module ppsa_stack_mem import ppsa_pkg::*; (
  input  logic               clk,
  input  stack_cmd_t         cmd,
  output logic [PN_BITS-1:0] rdata
);

  logic [PN_BITS-1:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[cmd.waddr] <= cmd.wdata;
    end
    if (cmd.re) begin
      rdata <= mem[cmd.raddr];
    end
  end

endmodule

### hw/rtl/ppsa_unsafe_table.sv
module ppsa_unsafe_table import ppsa_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  unsafe_cmd_t         cmd,
  input  logic [PN_BITS-1:0]  probe_pn,
  output logic                full,
  output logic [PNX_BITS-1:0] skip
);

  logic [ADDR_BITS-1:0] starts [UNSAFE_SLOTS];
  logic [ADDR_BITS-1:0] ends   [UNSAFE_SLOTS];
  logic [UC_BITS-1:0]   count;
  logic [UNSAFE_SLOTS-1:0] hit;
  logic [PNX_BITS-1:0]  end_pn [UNSAFE_SLOTS];
  logic [ADDR_BITS-1:0] probe_addr;

  assign full       = (count == UC_BITS'(UNSAFE_SLOTS));
  assign probe_addr = {probe_pn, {PAGE_SHIFT{1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.load && !full) begin
      count <= count + UC_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      starts[count[US_BITS-1:0]] <= cmd.range_start;
      ends[count[US_BITS-1:0]]   <= cmd.range_end;
    end
    for (int k = 0; k < UNSAFE_SLOTS; k++) begin
      hit[k]    <= (UC_BITS'(k) < count) && (probe_addr >= starts[k]) &&
                   (probe_addr < ends[k]);
      end_pn[k] <= {1'b0, ends[k][ADDR_BITS-1:PAGE_SHIFT]} +
                   PNX_BITS'(|ends[k][PAGE_SHIFT-1:0]);
    end
  end

  // furthest end page over the covering ranges
  always_comb begin
    skip = '0;
    for (int k = 0; k < UNSAFE_SLOTS; k++) begin
      if (hit[k] && (end_pn[k] > skip)) begin
        skip = end_pn[k];
      end
    end
  end

endmodule

### tb/physical_page_stack_allocator_core_test.sv
module physical_page_stack_allocator_core_test;
  import ppsa_pkg::*;

  typedef struct packed {
    logic [1:0]           mode;
    logic [ADDR_BITS-1:0] region_base;
    logic [ADDR_BITS-1:0] region_length;
    logic [ADDR_BITS-1:0] region_end;
    logic [7:0]           region_type;
    logic [ADDR_BITS-1:0] freed_page;
  } page_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [ADDR_BITS-1:0] page_address;
    logic [CNT_BITS-1:0]  pages_added;
    logic [1:0]           range_kind;
    logic [CNT_BITS-1:0]  free_pages_now;
  } page_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  ppsa_req_if req_bus ();
  ppsa_rsp_if rsp_bus ();

  physical_page_stack_allocator_core DUT (
    .clk (clk),
    .rst (rst),
    .req (req_bus.sink),
    .rsp (rsp_bus.source)
  );

  page_req_t pending_reqs[$];
  page_rsp_t expected_rsps[$];
  page_req_t on_bus;
  int mismatches = 0;

  // shadow of the free stack and the unsafe table
  logic [PN_BITS-1:0] page_mem [STACK_DEPTH];
  int free_depth = 0;
  logic [63:0] unsafe_lo [UNSAFE_SLOTS];
  logic [63:0] unsafe_hi [UNSAFE_SLOTS];
  int unsafe_used = 0;

  logic [31:0] cyc;
  int hold_left;
  int send_gap;
  int recv_gap;
  wire quiet = (cyc[9:8] == 2'b11);

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic logic [ADDR_BITS-1:0] rand52();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ADDR_BITS-1:0];
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic page_req_t noise_req(input logic [1:0] m);
    page_req_t r;
    r.mode = m;
    r.region_base = rand52();
    r.region_length = rand52();
    r.region_end = rand52();
    r.region_type = 8'($urandom);
    r.freed_page = rand52();
    return r;
  endfunction

  task automatic add_unsafe(input logic [63:0] lo, input logic [63:0] hi);
    page_req_t r;
    r = noise_req(MODE_ADD_UNSAFE);
    r.region_base = lo[ADDR_BITS-1:0];
    r.region_end = hi[ADDR_BITS-1:0];
    pending_reqs.push_back(r);
  endtask

  task automatic add_entry(input logic [63:0] base, input logic [63:0] len,
                           input logic [7:0] typ);
    page_req_t r;
    r = noise_req(MODE_MAP_ENTRY);
    r.region_base = base[ADDR_BITS-1:0];
    r.region_length = len[ADDR_BITS-1:0];
    r.region_type = typ;
    pending_reqs.push_back(r);
  endtask

  task automatic add_alloc();
    pending_reqs.push_back(noise_req(MODE_ALLOC));
  endtask

  task automatic add_free(input logic [63:0] addr);
    page_req_t r;
    r = noise_req(MODE_FREE);
    r.freed_page = addr[ADDR_BITS-1:0];
    pending_reqs.push_back(r);
  endtask

  function automatic page_req_t random_req(input int alloc_pct);
    page_req_t r;
    int roll;
    int pages;
    logic [63:0] b;
    logic [63:0] len;
    r = noise_req(MODE_ALLOC);
    if ($urandom_range(0, 99) < alloc_pct) return r;
    roll = $urandom_range(0, 9);
    if (roll < 2) begin
      r.mode = MODE_ADD_UNSAFE;
    end else if (roll < 6) begin
      r.mode = MODE_MAP_ENTRY;
      r.region_type = TYPE_USABLE;
      pages = $urandom_range(0, 8);
      b = 64'(rand52());
      case ($urandom_range(0, 9))
        0: b = 64'h0 + 64'($urandom_range(0, 32'h3FFFF));
        1: b = 64'hF000 + 64'($urandom_range(0, 32'h3FFFF));
        2: b = 64'h7F000 + 64'($urandom_range(0, 32'h3FFFF));
        3: b = 64'h3FE000 + 64'($urandom_range(0, 32'h3FFFF));
        4: b = 64'hFFFF_C000 + 64'($urandom_range(0, 32'h3FFFF));
        5, 6, 7: ;
        8: begin
          // near the top of the address space, any length
          b = 64'hF_FFFF_FFEF_0000 + 64'($urandom_range(0, 32'h10FFFF));
          pages = -1;
        end
        default: pages = $urandom_range(0, 512);
      endcase
      r.region_base = b[ADDR_BITS-1:0];
      if (pages >= 0) begin
        len = (64'(pages) << PAGE_SHIFT) | 64'($urandom_range(0, 4095));
        r.region_length = len[ADDR_BITS-1:0];
      end
    end else if (roll < 8) begin
      r.mode = MODE_MAP_ENTRY;
      case ($urandom_range(0, 3))
        0: r.region_type = TYPE_HIBERNATE;
        1: r.region_type = TYPE_DEFECTIVE;
        default: if (r.region_type == TYPE_USABLE) r.region_type = 8'd2;
      endcase
    end else begin
      r.mode = MODE_FREE;
    end
    return r;
  endfunction

  // advance the shadow state by one accepted request
  task automatic track_allocator(input page_req_t r);
    page_rsp_t e;
    logic [63:0] pn;
    logic [63:0] last;
    logic [63:0] nxt;
    logic [63:0] ep;
    logic [63:0] pa;
    logic [63:0] lim;
    int added;
    int k;
    bit stop;
    e = '0;
    added = 0;
    stop = 1'b0;
    lim = 64'd1 << PN_BITS;
    case (r.mode)
      MODE_ADD_UNSAFE: begin
        if (unsafe_used < UNSAFE_SLOTS) begin
          unsafe_lo[unsafe_used] = 64'(r.region_base);
          unsafe_hi[unsafe_used] = 64'(r.region_end);
          unsafe_used++;
        end else begin
          e.status = STATUS_FULL;
        end
      end
      MODE_MAP_ENTRY: begin
        if (r.region_type == TYPE_USABLE) begin
          pn = (64'(r.region_base) >> PAGE_SHIFT) + 64'(r.region_base[11:0] != 12'd0);
          last = pn + (64'(r.region_length) >> PAGE_SHIFT);
          if (last > lim) last = lim;
          while (pn < last && !stop) begin
            nxt = '0;
            pa = pn << PAGE_SHIFT;
            for (k = 0; k < unsafe_used; k++) begin
              if (pa >= unsafe_lo[k] && pa < unsafe_hi[k]) begin
                ep = (unsafe_hi[k] >> PAGE_SHIFT) + 64'(unsafe_hi[k][11:0] != 12'd0);
                if (ep > nxt) nxt = ep;
              end
            end
            if (nxt != 0) begin
              pn = nxt;
            end else if (free_depth >= STACK_DEPTH) begin
              e.status = STATUS_FULL;
              stop = 1'b1;
            end else begin
              page_mem[free_depth] = pn[PN_BITS-1:0];
              free_depth++;
              added++;
              pn++;
            end
          end
          e.pages_added = CNT_BITS'(added);
        end else begin
          e.status = STATUS_UNUSABLE;
          if (r.region_type == TYPE_HIBERNATE) e.range_kind = KIND_HIBERNATE;
          else if (r.region_type == TYPE_DEFECTIVE) e.range_kind = KIND_DEFECTIVE;
          else e.range_kind = KIND_RESERVED;
        end
      end
      MODE_ALLOC: begin
        if (free_depth > 0) begin
          free_depth--;
          e.page_address = {page_mem[free_depth], 12'd0};
        end else begin
          e.status = STATUS_EMPTY;
        end
      end
      MODE_FREE: begin
        if (free_depth < STACK_DEPTH) begin
          page_mem[free_depth] = r.freed_page[ADDR_BITS-1:PAGE_SHIFT];
          free_depth++;
        end else begin
          e.status = STATUS_FULL;
        end
      end
    endcase
    e.free_pages_now = CNT_BITS'(free_depth);
    expected_rsps.push_back(e);
  endtask

  task automatic check_response();
    page_rsp_t want;
    if (expected_rsps.size() == 0) begin
      report_mismatch("response with no request outstanding");
      return;
    end
    want = expected_rsps.pop_front();
    if (rsp_bus.status !== want.status)
      report_mismatch($sformatf("status got %0d want %0d", rsp_bus.status, want.status));
    if (rsp_bus.page_address !== want.page_address)
      report_mismatch($sformatf("page_address got %h want %h",
                                rsp_bus.page_address, want.page_address));
    if (rsp_bus.pages_added !== want.pages_added)
      report_mismatch($sformatf("pages_added got %0d want %0d",
                                rsp_bus.pages_added, want.pages_added));
    if (rsp_bus.range_kind !== want.range_kind)
      report_mismatch($sformatf("range_kind got %0d want %0d",
                                rsp_bus.range_kind, want.range_kind));
    if (rsp_bus.free_pages_now !== want.free_pages_now)
      report_mismatch($sformatf("free_pages_now got %0d want %0d",
                                rsp_bus.free_pages_now, want.free_pages_now));
  endtask

  // cycle count and long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      cyc <= '0;
      hold_left <= 0;
    end else begin
      cyc <= cyc + 1;
      if (cyc == 3000 || cyc == 9000) begin
        hold_left <= 400;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
    end
  end

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (req_bus.valid && req_bus.ready) track_allocator(on_bus);
      if (!req_bus.valid || req_bus.ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          req_bus.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          on_bus = pending_reqs.pop_front();
          req_bus.valid <= 1'b1;
          req_bus.mode <= on_bus.mode;
          req_bus.region_base <= on_bus.region_base;
          req_bus.region_length <= on_bus.region_length;
          req_bus.region_end <= on_bus.region_end;
          req_bus.region_type <= on_bus.region_type;
          req_bus.freed_page <= on_bus.freed_page;
          send_gap <= (quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    if (rst) begin
      rsp_bus.ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) check_response();
      if (hold_left > 0) begin
        rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        if (!quiet && $urandom_range(0, 3) == 0) recv_gap <= pick_gap();
      end
    end
  end

  initial begin
    #40000000;
    $display("physical_page_stack_allocator_core test failed");
    $finish;
  end

  initial begin
    int n;
    int alloc_pct;
    req_bus.valid = 1'b0;
    req_bus.mode = MODE_ALLOC;
    req_bus.region_base = '0;
    req_bus.region_length = '0;
    req_bus.region_end = '0;
    req_bus.region_type = '0;
    req_bus.freed_page = '0;
    rsp_bus.ready = 1'b0;

    // empty stack, extreme page addresses, unaligned free
    add_alloc();
    add_free(64'hF_FFFF_FFFF_FFFF);
    add_alloc();
    add_free(64'h0);
    add_alloc();

    // unsafe table: unaligned end, overlap, empty ranges, top of space, then full
    add_unsafe(64'h10000, 64'h13001);
    add_unsafe(64'h12000, 64'h20000);
    add_unsafe(64'h50000, 64'h40000);
    add_unsafe(64'h80800, 64'h81000);
    add_unsafe(64'hF_FFFF_FFF0_0000, 64'hF_FFFF_FFFF_FFFF);
    add_unsafe(64'h0, 64'h1000);
    add_unsafe(64'h1_0000_0000, 64'h1_0040_0000);
    add_unsafe(64'h300000, 64'h300000);
    add_unsafe(64'h0, 64'hF_FFFF_FFFF_FFFF);

    // map entries
    add_entry(64'h0, 64'h30000, TYPE_USABLE);
    add_entry(64'h7F001, 64'h2FFF, TYPE_USABLE);
    add_entry(64'h5000, 64'h0, TYPE_USABLE);
    add_entry(64'hF_FFFF_FFEF_E000, 64'hF_FFFF_FFFF_FFFF, TYPE_USABLE);
    add_entry(64'hF_FFFF_FFFF_FFFF, 64'hF_FFFF_FFFF_FFFF, TYPE_USABLE);
    add_entry(64'h1_0000_0000, 64'h80_0000, TYPE_USABLE);
    add_entry(64'h0, 64'hF_FFFF_FFFF_FFFF, TYPE_HIBERNATE);
    add_entry(64'hF_FFFF_FFFF_FFFF, 64'h1000, TYPE_DEFECTIVE);
    add_entry(64'h1000, 64'h1000, 8'd0);
    add_entry(64'h2000, 64'hF_FFFF_FFFF_FFFF, 8'hFF);
    add_alloc();
    add_alloc();

    // random part in chunks with a varying share of allocations
    alloc_pct = 45;
    for (n = 0; n < 700; n++) begin
      if (n % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: alloc_pct = 15;
          1: alloc_pct = 45;
          default: alloc_pct = 75;
        endcase
      end
      pending_reqs.push_back(random_req(alloc_pct));
    end

    // fill the stack, then hit the full cases
    add_entry(64'hFFFF_E000, 64'h2000_0000, TYPE_USABLE);
    add_free(64'h1234_5000);
    add_entry(64'h10000, 64'h10000, TYPE_USABLE);
    add_entry(64'h1000, 64'h1000, TYPE_USABLE);
    add_alloc();
    add_free(64'hA_BCDE_F012_3FFF);
    add_free(64'h7000);
    add_entry(64'h0, 64'h0, TYPE_HIBERNATE);
    add_alloc();
    add_alloc();
    add_alloc();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (pending_reqs.size() > 0 || req_bus.valid) @(negedge clk);
    while (expected_rsps.size() > 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0) begin
      $display("physical_page_stack_allocator_core test passed");
    end else begin
      $display("physical_page_stack_allocator_core test failed");
    end
    $finish;
  end

endmodule
